/* hdl/tsb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the bilinear texture sampler
// Request kinds, configuration codes, pipeline structs and coordinate folding.
// ----------------------------------------------------------------------------
package tsb_pkg;

	localparam int ADDR_W = 16;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam logic [31:0] MISSING_COLOR = 32'hFFFF00FF;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_TEX_WIDTH     = 3'd0,
		REG_TEX_HEIGHT    = 3'd1,
		REG_WRAP_U        = 3'd2,
		REG_WRAP_V        = 3'd3,
		REG_BILINEAR_ON   = 3'd4,
		REG_TEXTURE_BOUND = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_FILTER = 2'd1,
		KIND_POINT  = 2'd2,
		KIND_BLANK  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [8:0] width;
		logic [8:0] height;
		logic       wrap_u;
		logic       wrap_v;
		logic       bilinear_on;
		logic       texture_bound;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [3:0][15:0]  addr;
		logic [31:0]       wdata;
		logic [15:0]       fx;
		logic [15:0]       fy;
	} fetch_req_t;

	typedef struct packed {
		kind_t             kind;
		logic [15:0]       fx;
		logic [15:0]       fy;
		logic [3:0][31:0]  texel;
	} blend_req_t;

	// Wrap to the fraction, or clamp to the range zero to one, in Q1.16.
	function automatic logic [16:0] fold_coord(input logic [31:0] c, input logic wrap);
		logic [16:0] r;
		if (wrap) begin
			r = {1'b0, c[15:0]};
		end else if (c[31]) begin
			r = 17'd0;
		end else if (c > 32'h0001_0000) begin
			r = 17'h1_0000;
		end else begin
			r = c[16:0];
		end
		return r;
	endfunction

endpackage

/* hdl/tsb_coord.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_coord: coordinate pipeline
// Folds and scales the coordinates, picks texel positions and forms addresses.
// ----------------------------------------------------------------------------
module tsb_coord #(
	parameter int MAX_DIM = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsb_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [15:0]         texel_index,
	input  logic [31:0]         texel_value,
	input  logic [31:0]         coord_u,
	input  logic [31:0]         coord_v,
	output logic                req_valid,
	input  logic                req_ready,
	output tsb_pkg::fetch_req_t req
);

	logic [8:0] w_eff, h_eff, wm1, hm1;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic v_s1, v_s2, v_s3;
	tsb_pkg::kind_t kind_s1, kind_s2;
	logic [15:0] idx_s1, idx_s2;
	logic [31:0] wdata_s1, wdata_s2;
	logic [25:0] px_s1, py_s1;
	logic [8:0] xa_s2, xb_s2, ya_s2, yb_s2;
	logic [15:0] fx_s2, fy_s2;
	tsb_pkg::fetch_req_t req_s3;

	tsb_pkg::kind_t kind_in;
	logic [16:0] qu, qv;
	logic [8:0] xa, xb, ya, yb;
	logic [9:0] x0p1, y0p1, xr, yr;
	logic [25:0] pxr, pyr;
	logic [17:0] rowa, rowb, s00, s10, s01, s11;

	always_comb begin
		w_eff = cfg.width;
		if (cfg.width == 9'd0) begin
			w_eff = 9'd1;
		end else if (32'(cfg.width) > MAX_DIM) begin
			w_eff = 9'(MAX_DIM);
		end
		h_eff = cfg.height;
		if (cfg.height == 9'd0) begin
			h_eff = 9'd1;
		end else if (32'(cfg.height) > MAX_DIM) begin
			h_eff = 9'(MAX_DIM);
		end
		wm1 = w_eff - 9'd1;
		hm1 = h_eff - 9'd1;
	end

	assign rdy_s3 = !v_s3 || req_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		if (opcode == tsb_pkg::OP_WRITE) begin
			kind_in = tsb_pkg::KIND_WRITE;
		end else if (!cfg.texture_bound) begin
			kind_in = tsb_pkg::KIND_BLANK;
		end else if (cfg.bilinear_on) begin
			kind_in = tsb_pkg::KIND_FILTER;
		end else begin
			kind_in = tsb_pkg::KIND_POINT;
		end
		qu = tsb_pkg::fold_coord(coord_u, cfg.wrap_u);
		qv = tsb_pkg::fold_coord(coord_v, cfg.wrap_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			kind_s1 <= kind_in;
			idx_s1 <= texel_index;
			wdata_s1 <= texel_value;
			px_s1 <= {9'd0, qu} * {17'd0, wm1};
			py_s1 <= {9'd0, qv} * {17'd0, hm1};
		end
	end

	always_comb begin
		pxr = px_s1 + 26'h0008000;
		pyr = py_s1 + 26'h0008000;
		xr = pxr[25:16];
		yr = pyr[25:16];
		x0p1 = {1'b0, px_s1[24:16]} + 10'd1;
		y0p1 = {1'b0, py_s1[24:16]} + 10'd1;
		xb = (x0p1 > {1'b0, wm1}) ? wm1 : x0p1[8:0];
		yb = (y0p1 > {1'b0, hm1}) ? hm1 : y0p1[8:0];
		if (kind_s1 == tsb_pkg::KIND_POINT) begin
			xa = (xr > {1'b0, wm1}) ? wm1 : xr[8:0];
			ya = (yr > {1'b0, hm1}) ? hm1 : yr[8:0];
		end else begin
			xa = px_s1[24:16];
			ya = py_s1[24:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			kind_s2 <= kind_s1;
			idx_s2 <= idx_s1;
			wdata_s2 <= wdata_s1;
			xa_s2 <= xa;
			xb_s2 <= xb;
			ya_s2 <= ya;
			yb_s2 <= yb;
			fx_s2 <= px_s1[15:0];
			fy_s2 <= py_s1[15:0];
		end
	end

	always_comb begin
		rowa = {9'd0, ya_s2} * {9'd0, w_eff};
		rowb = {9'd0, yb_s2} * {9'd0, w_eff};
		s00 = rowa + {9'd0, xa_s2};
		s10 = rowa + {9'd0, xb_s2};
		s01 = rowb + {9'd0, xa_s2};
		s11 = rowb + {9'd0, xb_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			req_s3.kind <= kind_s2;
			req_s3.addr[0] <= (kind_s2 == tsb_pkg::KIND_WRITE) ? idx_s2 : s00[15:0];
			req_s3.addr[1] <= s10[15:0];
			req_s3.addr[2] <= s01[15:0];
			req_s3.addr[3] <= s11[15:0];
			req_s3.wdata <= wdata_s2;
			req_s3.fx <= fx_s2;
			req_s3.fy <= fy_s2;
		end
	end

	assign req_valid = v_s3;
	assign req = req_s3;

endmodule

/* hdl/tsb_fetch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_fetch: texel memory and read sequencer
// Runs writes and up to four reads per request on one port and gathers texels.
// ----------------------------------------------------------------------------
module tsb_fetch (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tsb_pkg::fetch_req_t req,
	output logic                bl_valid,
	input  logic                bl_ready,
	output tsb_pkg::blend_req_t bl_req
);

	logic [31:0] mem [tsb_pkg::STORE_DEPTH];
	logic [31:0] rdata_q;

	logic seq_v_q;
	tsb_pkg::fetch_req_t seq_q;
	logic [1:0] cnt_q;
	logic [1:0][31:0] tex_q;

	logic col_v_q, pend_q;
	tsb_pkg::blend_req_t col_q;

	logic col_free, we, re, done, to_col;
	logic [15:0] addr;

	assign col_free = !col_v_q || bl_ready;

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		done = 1'b0;
		to_col = 1'b0;
		addr = seq_q.addr[cnt_q];
		if (seq_v_q) begin
			unique case (seq_q.kind)
				tsb_pkg::KIND_WRITE: begin
					we = 1'b1;
					addr = seq_q.addr[0];
					done = 1'b1;
				end
				tsb_pkg::KIND_BLANK: begin
					done = col_free;
					to_col = col_free;
				end
				tsb_pkg::KIND_POINT: begin
					addr = seq_q.addr[0];
					re = col_free;
					done = col_free;
					to_col = col_free;
				end
				tsb_pkg::KIND_FILTER: begin
					if (cnt_q != 2'd3) begin
						re = 1'b1;
					end else begin
						re = col_free;
						done = col_free;
						to_col = col_free;
					end
				end
			endcase
		end
	end

	assign req_ready = !seq_v_q || done;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= seq_q.wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_v_q <= 1'b0;
			cnt_q <= 2'd0;
		end else if (req_ready) begin
			seq_v_q <= req_valid;
			cnt_q <= 2'd0;
		end else if (re) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			seq_q <= req;
		end
		if (re && seq_q.kind == tsb_pkg::KIND_FILTER && (cnt_q == 2'd1 || cnt_q == 2'd2)) begin
			tex_q[cnt_q[1]] <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_v_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (to_col) begin
			col_v_q <= 1'b1;
			pend_q <= re;
		end else begin
			pend_q <= 1'b0;
			if (bl_ready) begin
				col_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (to_col) begin
			col_q.kind <= seq_q.kind;
			col_q.fx <= seq_q.fx;
			col_q.fy <= seq_q.fy;
			col_q.texel[0] <= tex_q[0];
			col_q.texel[1] <= tex_q[1];
			col_q.texel[2] <= rdata_q;
		end else if (pend_q) begin
			col_q.texel[3] <= rdata_q;
		end
	end

	always_comb begin
		bl_req = col_q;
		if (pend_q) begin
			bl_req.texel[3] = rdata_q;
		end
	end

	assign bl_valid = col_v_q;

endmodule

/* hdl/tsb_blend.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsb_blend: bilinear blend pipeline and output register
// Weights four texels per channel, rounds half up and selects the result.
// ----------------------------------------------------------------------------
module tsb_blend (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                bl_valid,
	output logic                bl_ready,
	input  tsb_pkg::blend_req_t bl_req,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         sample_rgba
);

	logic rdy_b1, rdy_b2, rdy_b3, rdy_o;
	logic v_b1, v_b2, v_b3, out_v_q;
	tsb_pkg::kind_t kind_b1, kind_b2, kind_b3;
	logic [31:0] pass_b1, pass_b2, pass_b3;
	logic [15:0] fy_b1, fy_b2;
	logic [3:0][3:0][23:0] m_b1;
	logic [3:0][23:0] a_b2, b_b2;
	logic [3:0][39:0] sa_b3, sb_b3;
	logic [31:0] rgba_q;

	logic [16:0] wx0, wy0;
	logic [3:0][7:0] ch;
	logic [39:0] s, rs;
	logic [31:0] res;

	assign rdy_o = !out_v_q || !out_stall;
	assign rdy_b3 = !v_b3 || rdy_o;
	assign rdy_b2 = !v_b2 || rdy_b3;
	assign rdy_b1 = !v_b1 || rdy_b2;
	assign bl_ready = rdy_b1;

	assign wx0 = 17'h1_0000 - {1'b0, bl_req.fx};
	assign wy0 = 17'h1_0000 - {1'b0, fy_b2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_b1) begin
				v_b1 <= bl_valid;
			end
			if (rdy_b2) begin
				v_b2 <= v_b1;
			end
			if (rdy_b3) begin
				v_b3 <= v_b2;
			end
			if (rdy_o) begin
				out_v_q <= v_b3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_b1 && bl_valid) begin
			kind_b1 <= bl_req.kind;
			pass_b1 <= bl_req.texel[3];
			fy_b1 <= bl_req.fy;
			for (int c = 0; c < 4; c++) begin
				m_b1[c][0] <= 24'(bl_req.texel[0][c*8 +: 8]) * 24'(wx0);
				m_b1[c][1] <= 24'(bl_req.texel[1][c*8 +: 8]) * 24'(bl_req.fx);
				m_b1[c][2] <= 24'(bl_req.texel[2][c*8 +: 8]) * 24'(wx0);
				m_b1[c][3] <= 24'(bl_req.texel[3][c*8 +: 8]) * 24'(bl_req.fx);
			end
		end
		if (rdy_b2 && v_b1) begin
			kind_b2 <= kind_b1;
			pass_b2 <= pass_b1;
			fy_b2 <= fy_b1;
			for (int c = 0; c < 4; c++) begin
				a_b2[c] <= m_b1[c][0] + m_b1[c][1];
				b_b2[c] <= m_b1[c][2] + m_b1[c][3];
			end
		end
		if (rdy_b3 && v_b2) begin
			kind_b3 <= kind_b2;
			pass_b3 <= pass_b2;
			for (int c = 0; c < 4; c++) begin
				sa_b3[c] <= 40'(a_b2[c]) * 40'(wy0);
				sb_b3[c] <= 40'(b_b2[c]) * 40'(fy_b2);
			end
		end
		if (rdy_o && v_b3) begin
			rgba_q <= res;
		end
	end

	always_comb begin
		s = '0;
		rs = '0;
		for (int c = 0; c < 4; c++) begin
			s = sa_b3[c] + sb_b3[c];
			rs = s + 40'h00_8000_0000;
			ch[c] = rs[39:32];
		end
		unique case (kind_b3)
			tsb_pkg::KIND_FILTER: res = ch;
			tsb_pkg::KIND_POINT:  res = pass_b3;
			tsb_pkg::KIND_BLANK:  res = tsb_pkg::MISSING_COLOR;
			tsb_pkg::KIND_WRITE:  res = tsb_pkg::MISSING_COLOR;
		endcase
	end

	assign out_valid = out_v_q;
	assign sample_rgba = rgba_q;

endmodule

/* hdl/texture_sampler_bilinear.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_sampler_bilinear: bilinear and nearest sampler over an RGBA8888 store
// Loads texels and samples them with wrap or clamp addressing.
// ----------------------------------------------------------------------------
// A request is taken on the input channel when in_valid is high and in_stall
// is low. A write request (opcode 0) stores texel_value at texel_index and
// gives no result. A sample request (opcode 1) gives one sample_rgba on the
// output channel, in request order. The texel memory has one port, so a
// bilinear sample makes four reads on it in turn, a nearest sample one read,
// a write one write, and a sample with no texture bound none; the fetch
// stage takes a new request only once the last one has finished its accesses.
// Registers are written through the cfg channel, which is always ready; the
// user must write them only while no request is in flight, which the block
// itself does not enforce. Reset restores the register defaults and empties
// the pipeline; the texel memory is not cleared. When out_stall is high the
// result holds and the pipeline fills, then in_stall rises.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear #(
	parameter int MAX_DIM = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] texel_index,
	input  logic [31:0] texel_value,
	input  logic [31:0] coord_u,
	input  logic [31:0] coord_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sample_rgba,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	tsb_pkg::cfg_t cfg_q;
	tsb_pkg::fetch_req_t freq;
	tsb_pkg::blend_req_t breq;
	logic in_ready, f_valid, f_ready, b_valid, b_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width <= 9'd256;
			cfg_q.height <= 9'd256;
			cfg_q.wrap_u <= 1'b1;
			cfg_q.wrap_v <= 1'b1;
			cfg_q.bilinear_on <= 1'b1;
			cfg_q.texture_bound <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tsb_pkg::REG_TEX_WIDTH:     cfg_q.width <= cfg_data[8:0];
				tsb_pkg::REG_TEX_HEIGHT:    cfg_q.height <= cfg_data[8:0];
				tsb_pkg::REG_WRAP_U:        cfg_q.wrap_u <= cfg_data[0];
				tsb_pkg::REG_WRAP_V:        cfg_q.wrap_v <= cfg_data[0];
				tsb_pkg::REG_BILINEAR_ON:   cfg_q.bilinear_on <= cfg_data[0];
				tsb_pkg::REG_TEXTURE_BOUND: cfg_q.texture_bound <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tsb_coord #(.MAX_DIM(MAX_DIM)) u_coord (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.texel_index(texel_index),
		.texel_value(texel_value),
		.coord_u(coord_u),
		.coord_v(coord_v),
		.req_valid(f_valid),
		.req_ready(f_ready),
		.req(freq)
	);

	tsb_fetch u_fetch (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(f_valid),
		.req_ready(f_ready),
		.req(freq),
		.bl_valid(b_valid),
		.bl_ready(b_ready),
		.bl_req(breq)
	);

	tsb_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.bl_valid(b_valid),
		.bl_ready(b_ready),
		.bl_req(breq),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_rgba(sample_rgba)
	);

	assign in_stall = !in_ready;

endmodule
